@@ hw/rtl/round_robin_ready_ring_core_assert.svh @@
// Assertion macros for the round-robin ready ring checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ROUND_ROBIN_READY_RING_CORE_ASSERT_SVH
`define ROUND_ROBIN_READY_RING_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define RRR_ASSERT(LBL, PROP, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) PROP) else $error(MSG);

// Check a plain expression on every clock edge outside reset.
`define RRR_ASSERT_NOW(LBL, EXPR, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (EXPR)) else $error(MSG);

`endif

@@ hw/rtl/rrr_pkg.sv @@
// Shared types and constants for the round-robin ready ring.
// No dependencies; used by the cell, the controller, the top level and the checker.
package rrr_pkg;

    localparam int MAX_THREADS = 16;
    localparam int ID_BITS     = 8;
    localparam int THREAD_ID_W = 8;
    localparam int SLOT_BITS   = $clog2(MAX_THREADS);
    localparam int CNT_BITS    = $clog2(MAX_THREADS + 1);

    typedef enum logic [1:0] {
        OP_ADMIT  = 2'd0,
        OP_REMOVE = 2'd1,
        OP_NEXT   = 2'd2,
        OP_SET    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // Command that every cell of the chain carries out
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_ROTATE = 2'd1,
        CELL_DROP   = 2'd2,
        CELL_WRITE  = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd          cmd;
        logic [ID_BITS-1:0] wr_id;
    } t_cell_ctl;

    // What the controller sees of the ring: the active entry
    typedef struct packed {
        logic [ID_BITS-1:0] head_id;
        logic               head_valid;
    } t_ring_view;

endpackage

@@ hw/rtl/rrr_cell.sv @@
// One position of the ring chain: holds an id and an occupied flag.
// Depends on rrr_pkg for widths and the command encoding.
module rrr_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rrr_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_sel,
    input  logic [rrr_pkg::ID_BITS-1:0] i_head_id,
    input  logic [rrr_pkg::ID_BITS-1:0] i_right_id,
    input  logic                        i_right_valid,
    output logic [rrr_pkg::ID_BITS-1:0] o_id,
    output logic                        o_valid
);

    logic [rrr_pkg::ID_BITS-1:0] r_id;
    logic                        r_valid;

    // Occupied flag: set on write into the first free position, pulled left on drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_ctl.cmd)
                rrr_pkg::CELL_DROP:  r_valid <= i_right_valid;
                rrr_pkg::CELL_WRITE: if (i_sel) r_valid <= 1'b1;
                default:             r_valid <= r_valid;
            endcase
        end
    end

    // Id: rotate takes the neighbor, or the head at the tail of the ring
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            rrr_pkg::CELL_ROTATE: begin
                if (r_valid) r_id <= i_right_valid ? i_right_id : i_head_id;
            end
            rrr_pkg::CELL_DROP:  r_id <= i_right_id;
            rrr_pkg::CELL_WRITE: if (i_sel) r_id <= i_ctl.wr_id;
            default:             r_id <= r_id;
        endcase
    end

    assign o_id    = r_id;
    assign o_valid = r_valid;

endmodule

@@ hw/rtl/rrr_ctrl.sv @@
// Sequencer for the ring: decodes a word, steps the cell chain, builds the result.
// Depends on rrr_pkg for types, codes and widths.
module rrr_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_op,
    input  logic [rrr_pkg::THREAD_ID_W-1:0] i_thread_id,
    input  rrr_pkg::t_ring_view             i_view,
    output rrr_pkg::t_cell_ctl              o_ctl,
    output logic [rrr_pkg::CNT_BITS-1:0]    o_count,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rrr_pkg::THREAD_ID_W-1:0] o_active_id,
    output logic                            o_active_valid,
    output logic [4:0]                      o_thread_count,
    output logic [1:0]                      o_status
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_FIX  = 5'b01000,
        S_DONE = 5'b10000
    } t_fsm;

    t_fsm                            r_state, n_state;
    rrr_pkg::t_op                    r_op, n_op;
    logic [rrr_pkg::ID_BITS-1:0]     r_key, n_key;
    logic [rrr_pkg::CNT_BITS-1:0]    r_count, n_count;
    logic [rrr_pkg::SLOT_BITS-1:0]   r_step, n_step;
    rrr_pkg::t_status                r_status, n_status;
    logic                            r_out_valid, n_out_valid;
    logic [rrr_pkg::THREAD_ID_W-1:0] r_out_id, n_out_id;
    logic                            r_out_act, n_out_act;
    logic [4:0]                      r_out_cnt, n_out_cnt;
    logic [1:0]                      r_out_st, n_out_st;
    logic [rrr_pkg::CNT_BITS-1:0]    w_left;
    logic                            w_hit;

    // Rotations still needed after a drop to bring the old head back to the front
    assign w_left = r_count - rrr_pkg::CNT_BITS'(1) - rrr_pkg::CNT_BITS'(r_step);
    assign w_hit  = i_view.head_valid && (i_view.head_id == r_key);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_count     = r_count;
        n_step      = r_step;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_id    = r_out_id;
        n_out_act   = r_out_act;
        n_out_cnt   = r_out_cnt;
        n_out_st    = r_out_st;
        o_ctl.cmd   = rrr_pkg::CELL_HOLD;
        o_ctl.wr_id = r_key;
        case (r_state)
            S_IDLE: begin
                // Latch the incoming word
                if (i_in_valid) begin
                    n_op    = rrr_pkg::t_op'(i_op);
                    n_key   = i_thread_id[rrr_pkg::ID_BITS-1:0];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = rrr_pkg::ST_OK;
                n_state  = S_DONE;
                case (r_op)
                    rrr_pkg::OP_ADMIT: begin
                        // Append at the tail, just behind the active entry
                        if (r_count == rrr_pkg::CNT_BITS'(rrr_pkg::MAX_THREADS)) begin
                            n_status = rrr_pkg::ST_FULL;
                        end else begin
                            o_ctl.cmd = rrr_pkg::CELL_WRITE;
                            n_count   = r_count + rrr_pkg::CNT_BITS'(1);
                        end
                    end
                    rrr_pkg::OP_NEXT: begin
                        if (r_count == '0) begin
                            n_status = rrr_pkg::ST_EMPTY;
                        end else begin
                            o_ctl.cmd = rrr_pkg::CELL_ROTATE;
                        end
                    end
                    default: begin
                        // Remove and set-active search the ring from the head
                        if (r_count == '0) begin
                            n_status = rrr_pkg::ST_MISSING;
                        end else begin
                            n_step  = '0;
                            n_state = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = S_DONE;
                    if (r_op == rrr_pkg::OP_REMOVE) begin
                        // Drop the match; its successor moves to the front
                        o_ctl.cmd = rrr_pkg::CELL_DROP;
                        n_count   = r_count - rrr_pkg::CNT_BITS'(1);
                        if (r_step != '0 && w_left != '0) begin
                            n_step  = rrr_pkg::SLOT_BITS'(w_left);
                            n_state = S_FIX;
                        end
                    end
                end else begin
                    // Advance one position; a full turn without a match restores the ring
                    o_ctl.cmd = rrr_pkg::CELL_ROTATE;
                    if (rrr_pkg::CNT_BITS'(r_step) + rrr_pkg::CNT_BITS'(1) == r_count) begin
                        n_status = rrr_pkg::ST_MISSING;
                        n_state  = S_DONE;
                    end else begin
                        n_step = r_step + rrr_pkg::SLOT_BITS'(1);
                    end
                end
            end
            S_FIX: begin
                o_ctl.cmd = rrr_pkg::CELL_ROTATE;
                n_step    = r_step - rrr_pkg::SLOT_BITS'(1);
                if (r_step == rrr_pkg::SLOT_BITS'(1)) n_state = S_DONE;
            end
            S_DONE: begin
                // Load the result register once it is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_act   = i_view.head_valid;
                    n_out_id    = i_view.head_valid
                                ? rrr_pkg::THREAD_ID_W'(i_view.head_id)
                                : '0;
                    n_out_cnt   = 5'(r_count);
                    n_out_st    = r_status;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Work and result payload
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_step    <= n_step;
        r_status  <= n_status;
        r_out_id  <= n_out_id;
        r_out_act <= n_out_act;
        r_out_cnt <= n_out_cnt;
        r_out_st  <= n_out_st;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_count        = r_count;
    assign o_out_valid    = r_out_valid;
    assign o_active_id    = r_out_id;
    assign o_active_valid = r_out_act;
    assign o_thread_count = r_out_cnt;
    assign o_status       = r_out_st;

endmodule

@@ hw/rtl/round_robin_ready_ring_core.sv @@
// Round-robin ready ring. The ring lives in a chain of MAX_THREADS cells kept in service
// order: cell 0 holds the active id, the following cells its successors. Admit and next
// go straight from the exec state to the done state; remove and set-active step the
// chain one position per cycle, scanning at most a full ring for the id. A word is taken
// only while no item is in work; a finished result waits in its output register without
// blocking the next word.
module round_robin_ready_ring_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_op,
    input  logic [rrr_pkg::THREAD_ID_W-1:0] i_thread_id,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rrr_pkg::THREAD_ID_W-1:0] o_active_id,
    output logic                            o_active_valid,
    output logic [4:0]                      o_thread_count,
    output logic [1:0]                      o_status
);

    rrr_pkg::t_cell_ctl           w_ctl;
    rrr_pkg::t_ring_view          w_view;
    logic [rrr_pkg::CNT_BITS-1:0] w_count;
    logic [rrr_pkg::ID_BITS-1:0]  w_id    [rrr_pkg::MAX_THREADS];
    logic                         w_valid [rrr_pkg::MAX_THREADS];

    rrr_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_thread_id    (i_thread_id),
        .i_view         (w_view),
        .o_ctl          (w_ctl),
        .o_count        (w_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_active_id    (o_active_id),
        .o_active_valid (o_active_valid),
        .o_thread_count (o_thread_count),
        .o_status       (o_status)
    );

    // Chain of cells; each one reads its right neighbor, the last reads an empty slot
    for (genvar i = 0; i < rrr_pkg::MAX_THREADS; i++) begin : g_cell
        logic [rrr_pkg::ID_BITS-1:0] w_right_id;
        logic                        w_right_valid;

        if (i < rrr_pkg::MAX_THREADS - 1) begin : g_mid
            assign w_right_id    = w_id[i+1];
            assign w_right_valid = w_valid[i+1];
        end else begin : g_end
            assign w_right_id    = '0;
            assign w_right_valid = 1'b0;
        end

        rrr_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_sel         (w_count == rrr_pkg::CNT_BITS'(i)),
            .i_head_id     (w_id[0]),
            .i_right_id    (w_right_id),
            .i_right_valid (w_right_valid),
            .o_id          (w_id[i]),
            .o_valid       (w_valid[i])
        );
    end

    assign w_view.head_id    = w_id[0];
    assign w_view.head_valid = w_valid[0];

endmodule

@@ hw/rtl/rrr_checker.sv @@
// Port-level checks for the round-robin ready ring, bound to the top level.
// Depends on rrr_pkg and round_robin_ready_ring_core_assert.svh.
`include "round_robin_ready_ring_core_assert.svh"

module rrr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [rrr_pkg::THREAD_ID_W-1:0] o_active_id,
    input logic                            o_active_valid,
    input logic [4:0]                      o_thread_count,
    input logic [1:0]                      o_status
);

    logic        w_ring_empty;
    logic        w_ring_full;
    logic        w_act_ok;
    logic        w_id_ok;
    logic        w_st_ok;
    logic        w_out_stall;
    logic [15:0] w_out_word;

    assign w_ring_empty = (o_thread_count == 5'd0);
    assign w_ring_full  = (o_thread_count == 5'(rrr_pkg::MAX_THREADS));
    assign w_act_ok     = (o_active_valid != w_ring_empty);
    assign w_id_ok      = o_active_valid || (o_active_id == '0);
    assign w_st_ok      = ((o_status != rrr_pkg::ST_FULL) || w_ring_full)
                       && ((o_status != rrr_pkg::ST_EMPTY) || w_ring_empty);
    assign w_out_stall  = o_out_valid && !i_out_ready;
    assign w_out_word   = {o_active_id, o_active_valid, o_thread_count, o_status};

    // Active flag agrees with the entry count
    `RRR_ASSERT_NOW(a_act_vs_count, !o_out_valid || w_act_ok, "active flag disagrees with count")

    // An empty ring shows id zero
    `RRR_ASSERT_NOW(a_empty_id, !o_out_valid || w_id_ok, "empty ring with nonzero id")

    // Full status only on a full ring, empty status only on an empty ring
    `RRR_ASSERT_NOW(a_status_count, !o_out_valid || w_st_ok, "status disagrees with count")

    // A stalled result word holds
    `RRR_ASSERT(a_out_hold, w_out_stall |=> o_out_valid && $stable(w_out_word), "result moved")

endmodule

bind round_robin_ready_ring_core rrr_checker u_rrr_checker (.*);

@@ bench/round_robin_ready_ring_core_checker.sv @@
// Checker for the round-robin ready ring: watches both word channels, predicts each reply
// from its own copy of the ring in service order and compares it field by field.
// Depends on rrr_pkg for the op and status codes and the ring sizes.
module round_robin_ready_ring_core_checker
    import rrr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [1:0]             i_op,
    input  logic [THREAD_ID_W-1:0] i_thread_id,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [THREAD_ID_W-1:0] i_active_id,
    input  logic                   i_active_valid,
    input  logic [4:0]             i_thread_count,
    input  logic [1:0]             i_status,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [THREAD_ID_W-1:0] active_id;
        logic                   active_valid;
        logic [4:0]             thread_count;
        t_status                status;
    } t_ring_reply;

    // Ring in service order: entry 0 is the active thread, the rest follow it
    logic [ID_BITS-1:0] ready_ring[$];
    t_ring_reply        reply_queue[$];
    int                 mismatch_total = 0;

    // First match going forward from the active entry, or -1
    function automatic int find_thread(input logic [ID_BITS-1:0] id);
        foreach (ready_ring[k]) begin
            if (ready_ring[k] == id) return k;
        end
        return -1;
    endfunction

    // Apply one word to the ring and return the reply it should produce
    function automatic t_ring_reply schedule_step(input t_op op, input logic [ID_BITS-1:0] id);
        t_ring_reply        reply;
        int                 pos;
        logic [ID_BITS-1:0] head;
        reply = '0;
        reply.status = ST_OK;
        case (op)
            OP_ADMIT: begin
                // new thread lands just before the active one, so it is served last
                if (ready_ring.size() >= MAX_THREADS) reply.status = ST_FULL;
                else ready_ring.push_back(id);
            end
            OP_REMOVE: begin
                // removing the head makes its successor active, which is entry 0 again
                pos = find_thread(id);
                if (pos < 0) reply.status = ST_MISSING;
                else ready_ring.delete(pos);
            end
            OP_NEXT: begin
                if (ready_ring.size() == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    head = ready_ring.pop_front();
                    ready_ring.push_back(head);
                end
            end
            default: begin
                // rotate until the matching entry is at the front
                pos = find_thread(id);
                if (pos < 0) begin
                    reply.status = ST_MISSING;
                end else begin
                    for (int k = 0; k < pos; k++) ready_ring.push_back(ready_ring.pop_front());
                end
            end
        endcase
        reply.active_valid = (ready_ring.size() != 0);
        reply.active_id    = (ready_ring.size() != 0) ? ready_ring[0] : '0;
        reply.thread_count = 5'(ready_ring.size());
        return reply;
    endfunction

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatch_total++;
            if (mismatch_total <= 10)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
        end
    endtask

    // Score replies first: a word taken at this edge cannot have its reply here yet
    always @(posedge i_clk) begin
        t_ring_reply want;
        if (!i_rst_n) begin
            ready_ring.delete();
            reply_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (reply_queue.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("%0t: reply word with none predicted: id %0d count %0d status %0d",
                                 $realtime, i_active_id, i_thread_count, i_status);
                end else begin
                    want = reply_queue.pop_front();
                    compare_field("active_id", want.active_id, i_active_id);
                    compare_field("active_valid", want.active_valid, i_active_valid);
                    compare_field("thread_count", want.thread_count, i_thread_count);
                    compare_field("status", want.status, i_status);
                end
            end
            if (i_in_valid && i_in_ready)
                reply_queue.push_back(schedule_step(t_op'(i_op), i_thread_id[ID_BITS-1:0]));
        end
        o_fail_count <= mismatch_total;
        o_pending    <= reply_queue.size();
    end

endmodule

@@ bench/round_robin_ready_ring_core_tb.sv @@
// Top of the round-robin ready ring bench: clock, reset, scheduler words and output stalls.
// Depends on rrr_pkg, round_robin_ready_ring_core and round_robin_ready_ring_core_checker.
module round_robin_ready_ring_core_tb;
    import rrr_pkg::*;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    t_op                    op_word   = OP_NEXT;
    logic [THREAD_ID_W-1:0] id_word   = '0;
    logic                   out_ready = 1'b0;
    logic                   quiet_rx  = 1'b0;
    int                     rx_hold   = 0;

    logic                   in_ready;
    logic                   out_valid;
    logic [THREAD_ID_W-1:0] active_id;
    logic                   active_valid;
    logic [4:0]             thread_count;
    logic [1:0]             status;
    int                     fail_count;
    int                     pending_count;

    // Rough view of the ids in the ring, only to aim remove and set-active words
    logic [THREAD_ID_W-1:0] live_ids[$];

    round_robin_ready_ring_core DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_op           (op_word),
        .i_thread_id    (id_word),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_active_id    (active_id),
        .o_active_valid (active_valid),
        .o_thread_count (thread_count),
        .o_status       (status)
    );

    round_robin_ready_ring_core_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_op           (op_word),
        .i_thread_id    (id_word),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_active_id    (active_id),
        .i_active_valid (active_valid),
        .i_thread_count (thread_count),
        .i_status       (status),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the reply side in bursts of random length unless told to stay quiet
    always @(posedge clk) begin
        if (rx_hold != 0) begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end else if (!quiet_rx && $urandom_range(0, 6) == 0) begin
            out_ready <= 1'b0;
            rx_hold   <= $urandom_range(0, 17);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Present one word and hold it until taken; track the ids it should leave behind
    task automatic send_word(input t_op op, input logic [THREAD_ID_W-1:0] id);
        int k;
        op_word  <= op;
        id_word  <= id;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (op == OP_ADMIT && live_ids.size() < MAX_THREADS) begin
            live_ids.push_back(id);
        end else if (op == OP_REMOVE) begin
            for (k = 0; k < live_ids.size(); k++) begin
                if (live_ids[k] == id) begin
                    live_ids.delete(k);
                    break;
                end
            end
        end
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic [THREAD_ID_W-1:0] pick_live_id();
        return live_ids[$urandom_range(0, live_ids.size() - 1)];
    endfunction

    initial begin
        int                     n;
        int                     kind;
        int                     roll;
        int                     admit_lim;
        int                     remove_lim;
        int                     next_lim;
        logic                   calm;
        t_op                    op;
        logic [THREAD_ID_W-1:0] id;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty ring: next, remove and set-active all refuse
        send_word(OP_NEXT, 8'h00);
        send_word(OP_REMOVE, 8'h05);
        send_word(OP_SET, 8'h07);
        // Single entry: next keeps it, remove only drops a matching id
        send_word(OP_ADMIT, 8'h00);
        send_word(OP_NEXT, 8'hA5);
        send_word(OP_REMOVE, 8'h55);
        send_word(OP_REMOVE, 8'h00);
        // Fill the ring, ending on a duplicate of the first id, then overflow it
        send_word(OP_ADMIT, 8'hFF);
        for (n = 1; n < 16; n++) send_word(OP_ADMIT, 8'(n * 8'h11));
        send_word(OP_ADMIT, 8'h80);
        // Set-active on a duplicate picks the first match forward; drop the active one
        send_word(OP_NEXT, 8'h00);
        send_word(OP_SET, 8'hFF);
        send_word(OP_REMOVE, 8'hFF);

        // Random part: phases lean toward filling, mixing or draining the ring
        for (n = 0; n < 700; n++) begin
            kind = (n / 60) % 3;
            calm = (n >= 600) || ((n / 60) % 4 == 3);
            quiet_rx <= calm;
            if (!calm && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 18));
            case (kind)
                0: begin
                    admit_lim = 50; remove_lim = 65; next_lim = 85;
                end
                1: begin
                    admit_lim = 30; remove_lim = 60; next_lim = 80;
                end
                default: begin
                    admit_lim = 10; remove_lim = 60; next_lim = 80;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < admit_lim) op = OP_ADMIT;
            else if (roll < remove_lim) op = OP_REMOVE;
            else if (roll < next_lim) op = OP_NEXT;
            else op = OP_SET;
            if (op == OP_ADMIT)
                id = (live_ids.size() != 0 && $urandom_range(0, 5) == 0) ?
                     pick_live_id() : 8'($urandom_range(0, 255));
            else if (op == OP_NEXT || live_ids.size() == 0 || $urandom_range(0, 4) == 0)
                id = 8'($urandom_range(0, 255));
            else
                id = pick_live_id();
            send_word(op, id);
        end
        in_valid <= 1'b0;

        // Drain outstanding replies, then let the block settle
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("[round_robin_ready_ring_core] OK");
        end else begin
            $display("[round_robin_ready_ring_core] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #6000000;
        $display("[round_robin_ready_ring_core] ERROR");
        $finish;
    end

endmodule
